FILE: design/rvd_pkg.sv
// Shared types and constants for the radial vignette block.
`default_nettype none

package rvd_pkg;

  localparam int REG_W   = 13;   // config data width
  localparam int STR_W   = 13;   // strength width
  localparam int QW      = 13;   // quotient bits; |quotient| <= 4096
  localparam int AMT_W   = QW + 1;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_ROWS     = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLS     = 2'd1;
  localparam logic [IDX_W-1:0] REG_STRENGTH = 2'd2;

  localparam logic [REG_W-1:0] ROWS_RST = 13'd480;
  localparam logic [REG_W-1:0] COLS_RST = 13'd640;

  localparam logic signed [AMT_W-1:0] AMT_MAX = 14'sd4096;

  typedef enum logic [1:0] {
    OP_SQRT = 2'b01,
    OP_DIV  = 2'b10
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_cmd_t;

endpackage

`default_nettype wire

FILE: design/rvd_pix_if.sv
// Pixel request channel: three 8-bit channels with valid/ready.
`default_nettype none

interface rvd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;

  modport source (output valid, output chan0, output chan1, output chan2, input ready);
  modport sink   (input valid, input chan0, input chan1, input chan2, output ready);
endinterface

`default_nettype wire

FILE: design/rvd_res_if.sv
// Result request channel: adjusted pixel and end-of-frame flag.
`default_nettype none

interface rvd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] res0;
  logic [7:0] res1;
  logic [7:0] res2;
  logic       frame_end;

  modport source (output valid, output res0, output res1, output res2, output frame_end,
                  input ready);
  modport sink   (input valid, input res0, input res1, input res2, input frame_end,
                  output ready);
endinterface

`default_nettype wire

FILE: design/radial_vignette_darken.sv
// Radial vignette: darkens pixels by strength*(d/dmax)^2 around the frame center.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  pixel    | in  | valid/ready        | chan0, chan1, chan2 (8 bits each)
//  result   | out | valid/ready        | res0, res1, res2 (8 bits), frame_end
//  cfg      | in  | cfg_we, no stall   | cfg_idx, cfg_data (13 bits)
//
// One pixel at a time: pixel.ready stays low from accept until the result is
// loaded. The shared sqrt/divide unit does the root and both divides, one root
// bit pair or one quotient bit per cycle. A 1x1 frame skips the math.
// After reset and after every rows/cols write the corner radius is recomputed
// on the same unit, with pixel.ready low.
// The result register holds a finished pixel while result.ready is low; the
// block then waits before loading the next one.
`default_nettype none

module radial_vignette_darken
  import rvd_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [REG_W-1:0] cfg_data,
  rvd_pix_if.sink               pixel,
  rvd_res_if.source             result
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int OPW_RAW = (2 * DIM_W > QW + DIM_W + 1) ? 2 * DIM_W : QW + DIM_W + 1;
  localparam int OPW     = OPW_RAW + (OPW_RAW % 2);
  localparam int RES_W   = (OPW / 2 > QW) ? OPW / 2 : QW;
  localparam int MA_W    = (DIM_W + 1 > AMT_W) ? DIM_W + 1 : AMT_W;
  localparam int MB_W    = DIM_W + 1;
  localparam int P_W     = MA_W + MB_W;

  typedef enum logic [12:0] {
    S_RINIT  = 13'b1 << 0,
    S_IDLE   = 13'b1 << 1,
    S_SQR    = 13'b1 << 2,
    S_SQC    = 13'b1 << 3,
    S_ROOT   = 13'b1 << 4,
    S_RWAIT  = 13'b1 << 5,
    S_MUL1   = 13'b1 << 6,
    S_DIV1   = 13'b1 << 7,
    S_D1WAIT = 13'b1 << 8,
    S_MUL2   = 13'b1 << 9,
    S_DIV2   = 13'b1 << 10,
    S_D2WAIT = 13'b1 << 11,
    S_OUT    = 13'b1 << 12
  } state_t;

  // clamp a written size to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] fit_dim(input logic [REG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if ({19'd0, v} > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp8(input logic [7:0] c,
                                        input logic signed [AMT_W-1:0] a);
    logic signed [AMT_W:0] v;
    logic [7:0]            r;
    v = $signed({{(AMT_W-7){1'b0}}, c}) - $signed({a[AMT_W-1], a});
    if (v < 0) begin
      r = 8'd0;
    end else if (v > $signed((AMT_W+1)'(255))) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  state_t state;

  // configuration and position state
  logic [DIM_W-1:0]        rows, cols;
  logic signed [STR_W-1:0] strength;
  logic [DIM_W-1:0]        row_pos, col_pos;
  logic [DIM_W-1:0]        corner_radius;
  logic                    rad_job;   // current root is the corner radius

  // per-pixel datapath
  logic signed [DIM_W:0]   dr, dc;
  logic [OPW-1:0]          sq;
  logic [DIM_W-1:0]        d;
  logic signed [P_W-1:0]   prod;
  logic                    neg;
  logic signed [AMT_W-1:0] tq;
  logic signed [AMT_W-1:0] amount;
  logic [7:0]              c0, c1, c2;
  logic                    fe;

  // result register
  logic                    out_valid;
  logic [7:0]              r0, r1, r2;
  logic                    rfe;

  // shared multiplier and iterative unit
  logic signed [MA_W-1:0]  ma;
  logic signed [MB_W-1:0]  mb;
  logic signed [P_W-1:0]   mprod;
  logic [P_W-1:0]          prod_mag;
  unit_cmd_t               cmd;
  logic [OPW-1:0]          operand;
  logic                    unit_done;
  logic [RES_W-1:0]        unit_res;
  logic [QW-1:0]           q;

  logic                    pix_acc;
  logic                    last_col, last_row;
  logic                    load_out;
  logic [DIM_W-1:0]        cr, cc;

  assign cr       = rows >> 1;
  assign cc       = cols >> 1;
  assign pix_acc  = pixel.valid && pixel.ready;
  assign last_col = ({1'b0, col_pos} + 1'b1) >= {1'b0, cols};
  assign last_row = ({1'b0, row_pos} + 1'b1) >= {1'b0, rows};
  assign load_out = (state == S_OUT) && (!out_valid || result.ready);
  assign q        = unit_res[QW-1:0];
  assign prod_mag = prod[P_W-1] ? P_W'(-prod) : P_W'(prod);

  always_comb begin
    case (state)
      S_SQR: begin
        ma = MA_W'(dr);
        mb = dr;
      end
      S_SQC: begin
        ma = MA_W'(dc);
        mb = dc;
      end
      S_MUL1: begin
        ma = MA_W'(strength);
        mb = $signed({1'b0, d});
      end
      S_MUL2: begin
        ma = MA_W'(tq);
        mb = $signed({1'b0, d});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mprod = ma * mb;
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_SQRT;
    operand   = sq;
    case (state)
      S_ROOT: begin
        cmd.start = 1'b1;
      end
      S_DIV1, S_DIV2: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        operand   = prod_mag[OPW-1:0];
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  rvd_iter_unit #(
    .OPW   (OPW),
    .DIM_W (DIM_W),
    .RES_W (RES_W)
  ) u_unit (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .operand (operand),
    .divisor (corner_radius),
    .done    (unit_done),
    .result  (unit_res)
  );

  // control: sequencer, config registers, positions, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RINIT;
      rows          <= fit_dim(ROWS_RST);
      cols          <= fit_dim(COLS_RST);
      strength      <= '0;
      row_pos       <= '0;
      col_pos       <= '0;
      corner_radius <= '0;
      rad_job       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      case (state)
        S_RINIT:  begin
          rad_job <= 1'b1;
          state   <= S_SQR;
        end
        S_IDLE:   begin
          if (pix_acc) begin
            // position update follows raster order, frame wraps to 0,0
            if (last_col) begin
              col_pos <= '0;
              row_pos <= last_row ? '0 : row_pos + 1'b1;
            end else begin
              col_pos <= col_pos + 1'b1;
            end
            state <= (corner_radius == '0) ? S_OUT : S_SQR;
          end
        end
        S_SQR:    state <= S_SQC;
        S_SQC:    state <= S_ROOT;
        S_ROOT:   state <= S_RWAIT;
        S_RWAIT:  begin
          if (unit_done) begin
            if (rad_job) begin
              corner_radius <= unit_res[DIM_W-1:0];
              rad_job       <= 1'b0;
              state         <= S_IDLE;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1:   state <= S_DIV1;
        S_DIV1:   state <= S_D1WAIT;
        S_D1WAIT: if (unit_done) state <= S_MUL2;
        S_MUL2:   state <= S_DIV2;
        S_DIV2:   state <= S_D2WAIT;
        S_D2WAIT: if (unit_done) state <= S_OUT;
        S_OUT:    if (load_out) state <= S_IDLE;
        default:  state <= S_RINIT;
      endcase

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      // a size write restarts the radius job and the raster position
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROWS: begin
            rows    <= fit_dim(cfg_data);
            row_pos <= '0;
            col_pos <= '0;
            state   <= S_RINIT;
          end
          REG_COLS: begin
            cols    <= fit_dim(cfg_data);
            row_pos <= '0;
            col_pos <= '0;
            state   <= S_RINIT;
          end
          REG_STRENGTH: strength <= $signed(cfg_data[STR_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_RINIT: begin
        dr <= $signed({1'b0, cr});
        dc <= $signed({1'b0, cc});
      end
      S_IDLE: begin
        if (pix_acc) begin
          c0     <= pixel.chan0;
          c1     <= pixel.chan1;
          c2     <= pixel.chan2;
          fe     <= last_col && last_row;
          dr     <= $signed({1'b0, row_pos}) - $signed({1'b0, cr});
          dc     <= $signed({1'b0, col_pos}) - $signed({1'b0, cc});
          amount <= '0;
        end
      end
      S_SQR:  sq <= mprod[OPW-1:0];
      S_SQC:  sq <= sq + mprod[OPW-1:0];
      S_RWAIT: if (unit_done) d <= unit_res[DIM_W-1:0];
      S_MUL1, S_MUL2: prod <= mprod;
      S_DIV1, S_DIV2: neg <= prod[P_W-1];
      S_D1WAIT: begin
        if (unit_done) begin
          tq <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
      end
      S_D2WAIT: begin
        if (unit_done) begin
          amount <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
      end
      default: ;
    endcase

    if (load_out) begin
      r0  <= clamp8(c0, amount);
      r1  <= clamp8(c1, amount);
      r2  <= clamp8(c2, amount);
      rfe <= fe;
    end
  end

  assign pixel.ready      = (state == S_IDLE);
  assign result.valid     = out_valid;
  assign result.res0      = r0;
  assign result.res1      = r1;
  assign result.res2      = r2;
  assign result.frame_end = rfe;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    pix_acc |=> !pixel.ready)
    else $error("pixel accepted while previous pixel in progress");

  a_amount_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> ((amount <= AMT_MAX) && (amount >= -AMT_MAX)))
    else $error("darkening amount outside strength range");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((row_pos < rows) && (col_pos < cols)))
    else $error("raster position outside frame");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire

FILE: design/rvd_iter_unit.sv
// Iterative square root / restoring divider around one shared subtractor.
`default_nettype none

module rvd_iter_unit
  import rvd_pkg::*;
#(
  parameter int OPW   = 28,   // operand width, even
  parameter int DIM_W = 13,   // divisor width
  parameter int RES_W = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire unit_cmd_t        cmd,
  input  wire logic [OPW-1:0]   operand,
  input  wire logic [DIM_W-1:0] divisor,
  output logic                  done,
  output logic [RES_W-1:0]      result
);

  localparam int STEPS_MAX = (OPW / 2 > QW) ? OPW / 2 : QW;
  localparam int CNT_W     = $clog2(STEPS_MAX + 1);

  logic [OPW-1:0]   acc;    // sqrt: remainder; div: dividend low bits / quotient
  logic [OPW-1:0]   res;    // sqrt: root; div: partial remainder
  logic [OPW-1:0]   bitm;   // sqrt: current bit pair
  logic [DIM_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  op_t              mode;

  logic [DIM_W:0]   cur;
  logic [OPW:0]     lhs;
  logic [OPW:0]     rhs;
  logic [OPW+1:0]   diff;
  logic             ge;

  always_comb begin
    cur = {res[DIM_W-1:0], acc[QW-1]};
    if (mode == OP_SQRT) begin
      lhs = {1'b0, acc};
      rhs = {1'b0, res} + {1'b0, bitm};
    end else begin
      lhs = (OPW+1)'(cur);
      rhs = (OPW+1)'(dvs);
    end
    diff = {1'b0, lhs} - {1'b0, rhs};
    ge   = ~diff[OPW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      mode <= OP_SQRT;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        mode <= cmd.op;
        cnt  <= (cmd.op == OP_SQRT) ? CNT_W'(OPW / 2) : CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvs <= divisor;
      acc <= operand;
      if (cmd.op == OP_SQRT) begin
        res  <= '0;
        bitm <= OPW'(1) << (OPW - 2);
      end else begin
        // quotient fits QW bits, so the high part is already below the divisor
        res <= OPW'(operand[QW +: DIM_W]);
      end
    end else if (busy) begin
      if (mode == OP_SQRT) begin
        if (ge) begin
          acc <= diff[OPW-1:0];
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
      end else begin
        res          <= ge ? OPW'(diff[DIM_W:0]) : OPW'(cur);
        acc[QW-1:0]  <= {acc[QW-2:0], ge};
      end
    end
  end

  assign result = (mode == OP_SQRT) ? res[RES_W-1:0] : RES_W'(acc[QW-1:0]);

endmodule

`default_nettype wire
